[rtl/lvtr_pkg.sv]
// Shared widths, types and constants for the label-voting trilinear resampler.
// No dependencies.
package lvtr_pkg;

    localparam int FRAC_BITS = 8;
    localparam int FAC_W     = FRAC_BITS + 1;          // f or 2^FB - f
    localparam int PXY_W     = 2 * FAC_W;
    localparam int W_W       = 3 * FRAC_BITS + 1;      // weight, holds the full unit
    localparam int ACC_W     = 3 * FRAC_BITS + 8;      // colour * weight sums
    localparam int NCORN     = 8;
    localparam int NCH       = 3;
    localparam int QBITS     = 8;

    localparam logic [FAC_W-1:0] ONE   = FAC_W'(1) << FRAC_BITS;
    localparam logic [W_W-1:0]   TOTAL = W_W'(1) << (3 * FRAC_BITS);

    localparam logic [7:0] LAB_BG  = 8'd0;
    localparam logic [7:0] LAB_PRF = 8'd1;

    typedef logic [NCORN-1:0][31:0]      t_corners;
    typedef logic [NCORN-1:0][W_W-1:0]   t_weights;
    typedef logic [NCORN-1:0][7:0]       t_labels;
    typedef logic [NCH-1:0][ACC_W-1:0]   t_prod;

    typedef struct packed {
        logic [NCH-1:0][ACC_W-1:0] acc;
        logic [W_W-1:0]            bsum;
        logic [7:0]                lab;
        logic                      bg;
    } t_mrg;

    typedef struct packed {
        logic [NCH-1:0][ACC_W-1:0] rem;
        logic [NCH-1:0][QBITS-1:0] quo;
        logic [W_W-1:0]            den;
        logic [7:0]                lab;
        logic                      bg;
    } t_div;

endpackage

[rtl/lvtr_weight.sv]
// Two-stage trilinear weight generator; delays the corners alongside.
// Depends on lvtr_pkg.
module lvtr_weight (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  lvtr_pkg::t_corners            i_corners,
    input  logic [lvtr_pkg::FRAC_BITS-1:0] i_fx,
    input  logic [lvtr_pkg::FRAC_BITS-1:0] i_fy,
    input  logic [lvtr_pkg::FRAC_BITS-1:0] i_fz,
    output lvtr_pkg::t_weights            o_w,
    output lvtr_pkg::t_corners            o_corners
);
    logic [lvtr_pkg::FAC_W-1:0] fx, fy, fz, cx, cy, cz;
    logic [3:0][lvtr_pkg::PXY_W-1:0] r_pxy;
    logic [lvtr_pkg::FAC_W-1:0] r_cz, r_fz;
    lvtr_pkg::t_corners r_c1, r_c2;
    lvtr_pkg::t_weights r_w, n_w;

    assign fx = lvtr_pkg::FAC_W'(i_fx);
    assign fy = lvtr_pkg::FAC_W'(i_fy);
    assign fz = lvtr_pkg::FAC_W'(i_fz);
    assign cx = lvtr_pkg::ONE - fx;
    assign cy = lvtr_pkg::ONE - fy;
    assign cz = lvtr_pkg::ONE - fz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxy[0] <= cx * cy;
            r_pxy[1] <= fx * cy;
            r_pxy[2] <= fx * fy;
            r_pxy[3] <= cx * fy;
            r_cz     <= cz;
            r_fz     <= fz;
            r_c1     <= i_corners;
            r_c2     <= r_c1;
            r_w      <= n_w;
        end
    end

    // product taken at full weight width; the unit weight needs 25 bits
    always_comb begin
        for (int i = 0; i < lvtr_pkg::NCORN; i++) begin
            n_w[i] = lvtr_pkg::W_W'(r_pxy[i % 4]) *
                     lvtr_pkg::W_W'((i < 4) ? r_cz : r_fz);
        end
    end

    assign o_w       = r_w;
    assign o_corners = r_c2;
endmodule

[rtl/lvtr_lane.sv]
// One corner lane: weight sum of its label and colour-weight products.
// Depends on lvtr_pkg.
module lvtr_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_corner,
    input  logic [lvtr_pkg::W_W-1:0] i_w,
    input  lvtr_pkg::t_weights   i_ws,
    input  lvtr_pkg::t_labels    i_labs,
    output logic [lvtr_pkg::W_W-1:0] o_sum,
    output logic [7:0]           o_lab,
    output lvtr_pkg::t_prod      o_prod
);
    logic [lvtr_pkg::W_W-1:0] n_sum, r_sum;
    logic [7:0] r_lab;
    lvtr_pkg::t_prod r_prod, n_prod;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < lvtr_pkg::NCORN; j++) begin
            if (i_labs[j] == i_corner[31:24]) n_sum = n_sum + i_ws[j];
        end
        for (int c = 0; c < lvtr_pkg::NCH; c++) begin
            n_prod[c] = lvtr_pkg::ACC_W'(i_corner[8*c +: 8]) * lvtr_pkg::ACC_W'(i_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_lab  <= i_corner[31:24];
            r_prod <= n_prod;
        end
    end

    assign o_sum  = r_sum;
    assign o_lab  = r_lab;
    assign o_prod = r_prod;
endmodule

[rtl/lvtr_merge.sv]
// Merge stage: picks the winning label, flags full background, sums colours.
// Depends on lvtr_pkg.
module lvtr_merge (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  lvtr_pkg::t_weights                    i_sums,
    input  lvtr_pkg::t_labels                     i_labs,
    input  lvtr_pkg::t_prod [lvtr_pkg::NCORN-1:0] i_prods,
    output lvtr_pkg::t_mrg                        o_mrg
);
    logic [lvtr_pkg::W_W-1:0] n_bsum, r_bsum;
    logic [7:0] n_best, r_best;
    logic n_bg, r_bg;
    lvtr_pkg::t_labels r_labs;
    lvtr_pkg::t_prod [lvtr_pkg::NCORN-1:0] r_prods;
    lvtr_pkg::t_mrg r_mrg, n_mrg;

    // label 1 wins any tie, otherwise the lowest label
    always_comb begin
        n_bsum = i_sums[0];
        n_best = i_labs[0];
        n_bg   = 1'b0;
        for (int i = 0; i < lvtr_pkg::NCORN; i++) begin
            if (i_labs[i] == lvtr_pkg::LAB_BG && i_sums[i] == lvtr_pkg::TOTAL) n_bg = 1'b1;
            if (i_sums[i] > n_bsum ||
                (i_sums[i] == n_bsum && i_labs[i] != n_best &&
                 (i_labs[i] == lvtr_pkg::LAB_PRF ||
                  (n_best != lvtr_pkg::LAB_PRF && i_labs[i] < n_best)))) begin
                n_bsum = i_sums[i];
                n_best = i_labs[i];
            end
        end
    end

    always_comb begin
        n_mrg.acc  = '0;
        n_mrg.bsum = r_bsum;
        n_mrg.lab  = r_best;
        n_mrg.bg   = r_bg;
        for (int i = 0; i < lvtr_pkg::NCORN; i++) begin
            for (int c = 0; c < lvtr_pkg::NCH; c++) begin
                if (r_labs[i] == r_best) n_mrg.acc[c] = n_mrg.acc[c] + r_prods[i][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bsum  <= n_bsum;
            r_best  <= n_best;
            r_bg    <= n_bg;
            r_labs  <= i_labs;
            r_prods <= i_prods;
            r_mrg   <= n_mrg;
        end
    end

    assign o_mrg = r_mrg;
endmodule

[rtl/lvtr_div_stage.sv]
// One restoring-division step for all three colour channels.
// Depends on lvtr_pkg.
module lvtr_div_stage (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  lvtr_pkg::t_div               i_d,
    input  logic [lvtr_pkg::ACC_W-1:0]   i_dsh,
    output lvtr_pkg::t_div               o_d
);
    lvtr_pkg::t_div r_d, n_d;

    always_comb begin
        n_d = i_d;
        for (int c = 0; c < lvtr_pkg::NCH; c++) begin
            if (i_d.rem[c] >= i_dsh) begin
                n_d.rem[c] = i_d.rem[c] - i_dsh;
                n_d.quo[c] = {i_d.quo[c][lvtr_pkg::QBITS-2:0], 1'b1};
            end else begin
                n_d.quo[c] = {i_d.quo[c][lvtr_pkg::QBITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

[rtl/label_voting_trilinear_resample_core.sv]
// Label-voting trilinear resampler: one cell in, one voxel out.
// Registered stages: 2 weight, 1 lane, 2 merge, 8 divider steps; one cell per cycle while not stalled.
// The pipeline advances as a whole; it stalls only when the output transaction is held.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on lvtr_pkg, lvtr_weight, lvtr_lane, lvtr_merge, lvtr_div_stage.
module label_voting_trilinear_resample_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_corner_0,
    input  logic [31:0] i_corner_1,
    input  logic [31:0] i_corner_2,
    input  logic [31:0] i_corner_3,
    input  logic [31:0] i_corner_4,
    input  logic [31:0] i_corner_5,
    input  logic [31:0] i_corner_6,
    input  logic [31:0] i_corner_7,
    input  logic [7:0]  i_frac_x,
    input  logic [7:0]  i_frac_y,
    input  logic [7:0]  i_frac_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_label
);
    localparam int LAT = 5 + lvtr_pkg::QBITS;

    logic en;
    logic [LAT-1:0] r_vld;
    lvtr_pkg::t_corners corners_in, corners_w;
    lvtr_pkg::t_weights ws, sums;
    lvtr_pkg::t_labels  labs_w, labs_l;
    lvtr_pkg::t_prod [lvtr_pkg::NCORN-1:0] prods;
    lvtr_pkg::t_mrg mrg;
    lvtr_pkg::t_div dv [0:lvtr_pkg::QBITS];

    // whole pipeline moves unless a finished transaction is being held
    assign en      = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign corners_in = {i_corner_7, i_corner_6, i_corner_5, i_corner_4,
                         i_corner_3, i_corner_2, i_corner_1, i_corner_0};

    // weights: pairwise xy products, then times the z factor
    lvtr_weight u_weight (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_corners (corners_in),
        .i_fx      (i_frac_x[lvtr_pkg::FRAC_BITS-1:0]),
        .i_fy      (i_frac_y[lvtr_pkg::FRAC_BITS-1:0]),
        .i_fz      (i_frac_z[lvtr_pkg::FRAC_BITS-1:0]),
        .o_w       (ws),
        .o_corners (corners_w)
    );

    always_comb begin
        for (int i = 0; i < lvtr_pkg::NCORN; i++) labs_w[i] = corners_w[i][31:24];
    end

    // one lane per corner: the summed weight of its label and its colour products
    for (genvar g = 0; g < lvtr_pkg::NCORN; g++) begin : g_lane
        lvtr_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_corner (corners_w[g]),
            .i_w      (ws[g]),
            .i_ws     (ws),
            .i_labs   (labs_w),
            .o_sum    (sums[g]),
            .o_lab    (labs_l[g]),
            .o_prod   (prods[g])
        );
    end

    lvtr_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_sums  (sums),
        .i_labs  (labs_l),
        .i_prods (prods),
        .o_mrg   (mrg)
    );

    always_comb begin
        dv[0].rem = mrg.acc;
        dv[0].quo = '0;
        dv[0].den = mrg.bsum;
        dv[0].lab = mrg.lab;
        dv[0].bg  = mrg.bg;
    end

    // restoring divider, MSB of the quotient first; quotient fits eight bits
    for (genvar k = 0; k < lvtr_pkg::QBITS; k++) begin : g_div
        lvtr_div_stage u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (dv[k]),
            .i_dsh (lvtr_pkg::ACC_W'(dv[k].den) << (lvtr_pkg::QBITS - 1 - k)),
            .o_d   (dv[k+1])
        );
    end

    // whole cell background: all fields zero
    assign o_red   = dv[lvtr_pkg::QBITS].bg ? 8'd0 : dv[lvtr_pkg::QBITS].quo[0];
    assign o_green = dv[lvtr_pkg::QBITS].bg ? 8'd0 : dv[lvtr_pkg::QBITS].quo[1];
    assign o_blue  = dv[lvtr_pkg::QBITS].bg ? 8'd0 : dv[lvtr_pkg::QBITS].quo[2];
    assign o_label = dv[lvtr_pkg::QBITS].bg ? 8'd0 : dv[lvtr_pkg::QBITS].lab;

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input not stalled while output held");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !mrg.bg |-> mrg.bsum != '0)
        else $error("winning weight is zero");

    a_rem_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !dv[lvtr_pkg::QBITS].bg |->
            dv[lvtr_pkg::QBITS].rem[0] < lvtr_pkg::ACC_W'(dv[lvtr_pkg::QBITS].den) &&
            dv[lvtr_pkg::QBITS].rem[1] < lvtr_pkg::ACC_W'(dv[lvtr_pkg::QBITS].den) &&
            dv[lvtr_pkg::QBITS].rem[2] < lvtr_pkg::ACC_W'(dv[lvtr_pkg::QBITS].den))
        else $error("colour quotient overflowed");
endmodule
